[design/zlpd_pkg.sv]
`default_nettype none

package zlpd_pkg;

  // zone count
  localparam int unsigned MAX_ZONES = 4;
  localparam int unsigned ZONES_DEF = 4;

  // field widths
  localparam int unsigned LVL_W    = 2;
  localparam int unsigned PERIOD_W = 4;
  localparam int unsigned HOLD_W   = 10;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned CFG_W    = HOLD_W;

  // register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 4'd10;
  localparam logic [HOLD_W-1:0]   HOLD_RST   = 10'd100;
  localparam logic [7:0]          BYTE_RST   = 8'hFF;

  typedef enum logic [1:0] {
    OP_PWM    = 2'd0,
    OP_MOTION = 2'd1,
    OP_CTRL   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_AUTO = 2'd0,
    MODE_ON   = 2'd1,
    MODE_OFF  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_POLAR  = 2'd1,
    REG_PERIOD = 2'd2,
    REG_HOLD   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    LVL_OFF  = 2'd0,
    LVL_30   = 2'd1,
    LVL_60   = 2'd2,
    LVL_FULL = 2'd3
  } lvl_e;

  // shared control for every zone slice
  typedef struct packed {
    logic                en;
    logic [1:0]          op;
    logic [1:0]          mode;
    logic                sched;
    logic [LVL_W-1:0]    amb;
    logic [PERIOD_W-1:0] period;
    logic [HOLD_W-1:0]   hold;
    logic [PERIOD_W-1:0] step;
  } ctrl_t;

  // per-zone status after the beat
  typedef struct packed {
    logic             on;
    logic             fresh;
    logic             motion;
    logic [LVL_W-1:0] level;
  } zone_stat_t;

  // floor(30 * p / 100) and floor(60 * p / 100) for p = 0..15
  localparam logic [PERIOD_W-1:0] DUTY30 [16] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2,
    4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4
  };
  localparam logic [PERIOD_W-1:0] DUTY60 [16] = '{
    4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4,
    4'd4, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd9
  };

  function automatic logic [PERIOD_W-1:0] duty_steps(logic [LVL_W-1:0] lvl,
                                                     logic [PERIOD_W-1:0] period);
    logic [PERIOD_W-1:0] res;
    case (lvl)
      LVL_OFF:  res = '0;
      LVL_30:   res = DUTY30[period];
      LVL_60:   res = DUTY60[period];
      LVL_FULL: res = period;
      default:  res = '0;
    endcase
    return res;
  endfunction

  function automatic logic [PCT_W-1:0] level_pct(logic [LVL_W-1:0] lvl);
    logic [PCT_W-1:0] res;
    case (lvl)
      LVL_OFF:  res = 7'd0;
      LVL_30:   res = 7'd30;
      LVL_60:   res = 7'd60;
      LVL_FULL: res = 7'd100;
      default:  res = 7'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[design/zlpd_zone.sv]
`default_nettype none

module zlpd_zone (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire zlpd_pkg::ctrl_t    ctrl_i,
  input  wire logic               pin_i,
  output zlpd_pkg::zone_stat_t    stat_o
);
  import zlpd_pkg::*;

  logic [LVL_W-1:0]    level_q, level_d;
  logic [PERIOD_W-1:0] duty_q, duty_d;
  logic                motion_q, motion_d;
  logic [HOLD_W-1:0]   hold_q, hold_d;
  logic [LVL_W-1:0]    lvl_new;
  logic                fresh;

  // level this zone would take on a control beat
  always_comb begin
    if (ctrl_i.mode == MODE_ON) begin
      lvl_new = LVL_FULL;
    end else if (ctrl_i.mode == MODE_OFF || !ctrl_i.sched) begin
      lvl_new = LVL_OFF;
    end else if (motion_q) begin
      lvl_new = LVL_FULL;
    end else begin
      lvl_new = ctrl_i.amb;
    end
  end

  always_comb begin
    level_d  = level_q;
    duty_d   = duty_q;
    motion_d = motion_q;
    hold_d   = hold_q;
    fresh    = 1'b0;
    case (ctrl_i.op)
      OP_MOTION: begin
        if (pin_i) begin
          fresh    = !motion_q;
          motion_d = 1'b1;
          hold_d   = ctrl_i.hold;
        end
        // a zero hold never counts down, so the mark sticks
        if (hold_d != '0) begin
          hold_d = hold_d - 1'b1;
          if (hold_d == '0) begin
            motion_d = 1'b0;
          end
        end
      end
      OP_CTRL: begin
        if (lvl_new != level_q) begin
          level_d = lvl_new;
          duty_d  = duty_steps(lvl_new, ctrl_i.period);
        end
      end
      default: ;
    endcase
  end

  assign stat_o.on     = (ctrl_i.step < duty_q);
  assign stat_o.fresh  = fresh;
  assign stat_o.motion = motion_d;
  assign stat_o.level  = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= LVL_OFF;
      duty_q   <= '0;
      motion_q <= 1'b0;
      hold_q   <= '0;
    end else if (ctrl_i.en) begin
      level_q  <= level_d;
      duty_q   <= duty_d;
      motion_q <= motion_d;
      hold_q   <= hold_d;
    end
  end

endmodule

`default_nettype wire

[design/zone_led_pwm_motion_dimmer.sv]
`default_nettype none

// Four-zone LED dimmer with motion boost. Each input beat is a PWM tick, a
// motion tick or a control update, and every beat returns exactly one result
// beat holding the shift-register byte last written, a write strobe (set only
// when a PWM tick changed the byte), the per-zone motion marks, the zones that
// just became active, the packed two-bit zone levels and the brightest zone's
// percent. An accepted beat waits in an input register and then updates state
// and loads the result register in the same cycle, so the block takes one beat
// per clock while the result channel is not stalled; the input register lets a
// new beat in while a result still waits downstream. Registers (light mode, LED
// polarity, PWM period, motion hold) are written through the plain write port
// by the user only while no beat is in flight; the block does not enforce it.
// Duty steps come from a small constant table indexed by level and period.

module zone_led_pwm_motion_dimmer #(
  parameter int unsigned ZONES = zlpd_pkg::ZONES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // config write port
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [zlpd_pkg::CFG_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                operation_i,
  input  wire logic [3:0]                motion_pins_i,
  input  wire logic                      schedule_on_i,
  input  wire logic [1:0]                ambient_level_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [7:0]                     shift_byte_o,
  output logic                           shift_write_o,
  output logic [3:0]                     motion_active_o,
  output logic [3:0]                     motion_new_o,
  output logic [6:0]                     peak_pct_o,
  output logic [7:0]                     zone_levels_o
);
  import zlpd_pkg::*;

  // configuration registers
  logic [1:0]          mode_q;
  logic                polar_q;
  logic [PERIOD_W-1:0] period_q;
  logic [HOLD_W-1:0]   hold_q;

  // input register
  logic                s1_valid_q;
  logic [1:0]          op_q;
  logic [3:0]          pins_q;
  logic                sched_q;
  logic [1:0]          amb_q;

  // block state outside the zone slices
  logic [PERIOD_W-1:0] step_q, step_d, step_inc;
  logic [7:0]          last_byte_q, last_byte_d;

  // result register
  logic                out_valid_q;
  logic [7:0]          res_byte_q;
  logic                res_write_q;
  logic [3:0]          res_active_q, res_new_q;
  logic [PCT_W-1:0]    res_pct_q;
  logic [7:0]          res_levels_q;

  logic                advance;
  ctrl_t               ctrl;
  zone_stat_t          stat [MAX_ZONES];

  logic [7:0]          on_byte, new_byte;
  logic                wrote;
  logic [3:0]          active, fresh;
  logic [7:0]          levels;
  logic [LVL_W-1:0]    max_lvl;

  // the input register moves on whenever the result register is free
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_AUTO;
      polar_q  <= 1'b0;
      period_q <= PERIOD_RST;
      hold_q   <= HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_wdata_i[1:0];
        REG_POLAR:  polar_q  <= cfg_wdata_i[0];
        REG_PERIOD: period_q <= cfg_wdata_i[PERIOD_W-1:0];
        REG_HOLD:   hold_q   <= cfg_wdata_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= operation_i;
      pins_q  <= motion_pins_i;
      sched_q <= schedule_on_i;
      amb_q   <= ambient_level_i;
    end
  end

  // ---------------------------------------------------------------------------
  // zone slices
  // ---------------------------------------------------------------------------
  assign ctrl.en     = advance;
  assign ctrl.op     = op_q;
  assign ctrl.mode   = mode_q;
  assign ctrl.sched  = sched_q;
  assign ctrl.amb    = amb_q;
  assign ctrl.period = period_q;
  assign ctrl.hold   = hold_q;
  assign ctrl.step   = step_q;

  for (genvar gz = 0; gz < MAX_ZONES; gz++) begin : g_zone
    if (gz < ZONES) begin : g_used
      zlpd_zone u_zone (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .pin_i  (pins_q[gz]),
        .stat_o (stat[gz])
      );
    end else begin : g_unused
      // zones beyond the configured count never drive anything
      assign stat[gz] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // pwm byte and step counter
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int z = 0; z < MAX_ZONES; z++) begin
      on_byte[2*z +: 2] = {2{stat[z].on}};
    end
  end

  // active-low leds get the inverted byte
  assign new_byte    = polar_q ? on_byte : ~on_byte;
  assign wrote       = (op_q == OP_PWM) && (new_byte != last_byte_q);
  assign last_byte_d = wrote ? new_byte : last_byte_q;

  // counter wraps at the period, also when the period shrank under it
  assign step_inc = step_q + 1'b1;
  assign step_d   = (step_inc >= period_q) ? '0 : step_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      last_byte_q <= BYTE_RST;
    end else if (advance && op_q == OP_PWM) begin
      step_q      <= step_d;
      last_byte_q <= last_byte_d;
    end
  end

  // ---------------------------------------------------------------------------
  // status gathering
  // ---------------------------------------------------------------------------
  always_comb begin
    max_lvl = LVL_OFF;
    for (int z = 0; z < MAX_ZONES; z++) begin
      active[z]         = stat[z].motion;
      fresh[z]          = stat[z].fresh;
      levels[2*z +: 2]  = stat[z].level;
      if (stat[z].level > max_lvl) begin
        max_lvl = stat[z].level;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_byte_q   <= last_byte_d;
      res_write_q  <= wrote;
      res_active_q <= active;
      res_new_q    <= fresh;
      res_pct_q    <= level_pct(max_lvl);
      res_levels_q <= levels;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign shift_byte_o         = res_byte_q;
  assign shift_write_o        = res_write_q;
  assign motion_active_o      = res_active_q;
  assign motion_new_o         = res_new_q;
  assign peak_pct_o           = res_pct_q;
  assign zone_levels_o        = res_levels_q;

endmodule

`default_nettype wire

[design/zlpd_check.sv]
`default_nettype none

module zlpd_check (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [7:0]                 shift_byte_o,
  input wire logic [3:0]                 motion_active_o,
  input wire logic [6:0]                 peak_pct_o,
  input wire logic [7:0]                 zone_levels_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(shift_byte_o)
      && $stable(zone_levels_o) && $stable(motion_active_o))
    else $error("result beat changed while stalled");

  // input side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with result register free");

  // dark display exactly when every zone is off
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((peak_pct_o == 7'd0) == (zone_levels_o == 8'd0)))
    else $error("brightness disagrees with zone levels");

  // full brightness exactly when some zone is at full level
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((peak_pct_o == 7'd100) ==
      (zone_levels_o[1:0] == 2'd3 || zone_levels_o[3:2] == 2'd3 ||
       zone_levels_o[5:4] == 2'd3 || zone_levels_o[7:6] == 2'd3)))
    else $error("full brightness disagrees with zone levels");

endmodule

bind zone_led_pwm_motion_dimmer zlpd_check u_zlpd_check (.*);

`default_nettype wire
